@@ src/rfid_ascii_frame_parser_defines.svh @@
// ----------------------------------------------------------------------------
// RFID ASCII frame parser assertion macros
// Shared property shapes for the checker of the frame parser.
// ----------------------------------------------------------------------------
`ifndef RFID_ASCII_FRAME_PARSER_DEFINES_SVH
`define RFID_ASCII_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAFP_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RAFP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

@@ src/rfid_afp_pkg.sv @@
// ----------------------------------------------------------------------------
// RFID ASCII frame parser package
// Character codes, status codes and fixed field widths of the parser.
// ----------------------------------------------------------------------------
package rfid_afp_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TAG_ID_W = 40;
  localparam int unsigned CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] CH_STX  = 8'h02;
  localparam logic [CHAR_W-1:0] CH_ETX  = 8'h03;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F = 8'h46;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_START   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HEX     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CR      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_LF      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_ETX     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CS_MISMATCH = 3'd6;

endpackage

@@ src/rfid_afp_byte_if.sv @@
// ----------------------------------------------------------------------------
// RFID ASCII frame parser character channel
// Valid/ready channel that carries one received serial character per beat.
// ----------------------------------------------------------------------------
interface rfid_afp_byte_if
  import rfid_afp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/rfid_afp_result_if.sv @@
// ----------------------------------------------------------------------------
// RFID ASCII frame parser result channel
// Valid/ready channel that carries one frame verdict per beat.
// ----------------------------------------------------------------------------
interface rfid_afp_result_if
  import rfid_afp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_ID_W-1:0] tag_id;
  logic [CHAR_W-1:0]   received_checksum;

  modport source (output valid, output status, output tag_id, output received_checksum,
                  input ready);
  modport sink (input valid, input status, input tag_id, input received_checksum,
                output ready);
endinterface

@@ src/rfid_ascii_frame_parser.sv @@
// ----------------------------------------------------------------------------
// RFID ASCII frame parser
// Follows the position in an ASCII hex tag frame, packs the tag ID, keeps an
// XOR over the ID bytes and reports one verdict per frame or per bad byte.
//
//   channel  dir  beat contents
//   rx       in   rx_byte (8)
//   tag      out  status (3), tag_id (40), received_checksum (8)
//
// Each accepted character is decoded in the cycle it arrives; a verdict is
// in the result register in the cycle after the character that causes it.
// One character per cycle is taken while the result register is empty or
// being emptied; a stalled verdict holds rx.ready low until it is taken.
// Reset returns the frame position to the start character and drops any
// pending verdict.
// ----------------------------------------------------------------------------
module rfid_ascii_frame_parser
  import rfid_afp_pkg::*;
#(
  parameter int unsigned TAG_BYTES = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  rfid_afp_byte_if.sink            rx,
  rfid_afp_result_if.source        tag
);

  localparam int unsigned DATA_CHARS = 2 * TAG_BYTES;
  localparam int unsigned POS_CS_LO  = DATA_CHARS + 2;
  localparam int unsigned POS_CR     = DATA_CHARS + 3;
  localparam int unsigned POS_LF     = DATA_CHARS + 4;
  localparam int unsigned POS_ETX    = DATA_CHARS + 5;
  localparam int unsigned POS_W      = $clog2(POS_ETX + 1);
  localparam int unsigned ID_W       = 8 * TAG_BYTES;

  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  logic [ID_W-1:0]     id_shift;
  logic [ID_W-1:0]     id_shift_next;
  logic [CHAR_W-1:0]   frame_checksum;
  logic [CHAR_W-1:0]   frame_checksum_next;
  logic [CHAR_W-1:0]   running_xor;
  logic [CHAR_W-1:0]   running_xor_next;

  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [TAG_ID_W-1:0] res_tag_id;
  logic [CHAR_W-1:0]   res_checksum;

  logic                accept;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [TAG_ID_W-1:0] emit_tag_id;
  logic [CHAR_W-1:0]   emit_checksum;
  logic                is_digit;
  logic                is_letter;
  logic [3:0]          nib;
  logic [ID_W-1:0]     id_shifted;

  assign rx.ready = !res_valid || tag.ready;
  assign accept   = rx.valid && rx.ready;

  assign is_digit   = (rx.rx_byte >= CH_ZERO) && (rx.rx_byte <= CH_NINE);
  assign is_letter  = (rx.rx_byte >= CH_UC_A) && (rx.rx_byte <= CH_UC_F);
  assign nib        = is_digit ? rx.rx_byte[3:0] : 4'(rx.rx_byte[3:0] + 4'd9);
  assign id_shifted = {id_shift[ID_W-5:0], nib};

  always_comb begin
    pos_next            = pos;
    id_shift_next       = id_shift;
    frame_checksum_next = frame_checksum;
    running_xor_next    = running_xor;
    emit                = 1'b0;
    emit_status         = ST_OK;
    emit_tag_id         = '0;
    emit_checksum       = '0;

    if (pos == '0) begin
      if (rx.rx_byte == CH_STX) begin
        pos_next = POS_W'(1);
      end else begin
        emit        = 1'b1;
        emit_status = ST_BAD_START;
      end
    end else if (pos <= POS_W'(POS_CS_LO)) begin
      if (is_digit || is_letter) begin
        pos_next = pos + POS_W'(1);
        if (pos <= POS_W'(DATA_CHARS)) begin
          id_shift_next = id_shifted;
          if (!pos[0]) begin
            running_xor_next = running_xor ^ id_shifted[CHAR_W-1:0];
          end
        end else begin
          frame_checksum_next = {frame_checksum[3:0], nib};
        end
      end else begin
        emit        = 1'b1;
        emit_status = ST_BAD_HEX;
      end
    end else if (pos == POS_W'(POS_CR)) begin
      if (rx.rx_byte == CH_CR) begin
        pos_next = pos + POS_W'(1);
      end else begin
        emit        = 1'b1;
        emit_status = ST_BAD_CR;
      end
    end else if (pos == POS_W'(POS_LF)) begin
      if (rx.rx_byte == CH_LF) begin
        pos_next = pos + POS_W'(1);
      end else begin
        emit        = 1'b1;
        emit_status = ST_BAD_LF;
      end
    end else begin
      emit = 1'b1;
      if (rx.rx_byte != CH_ETX) begin
        emit_status = ST_BAD_ETX;
      end else begin
        emit_status   = (frame_checksum == running_xor) ? ST_OK : ST_CS_MISMATCH;
        emit_tag_id   = TAG_ID_W'(id_shift);
        emit_checksum = frame_checksum;
      end
    end

    if (emit) begin
      pos_next            = '0;
      id_shift_next       = '0;
      frame_checksum_next = '0;
      running_xor_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      id_shift       <= '0;
      frame_checksum <= '0;
      running_xor    <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        pos            <= pos_next;
        id_shift       <= id_shift_next;
        frame_checksum <= frame_checksum_next;
        running_xor    <= running_xor_next;
      end
      if (accept && emit) begin
        res_valid <= 1'b1;
      end else if (tag.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_status   <= emit_status;
      res_tag_id   <= emit_tag_id;
      res_checksum <= emit_checksum;
    end
  end

  assign tag.valid             = res_valid;
  assign tag.status            = res_status;
  assign tag.tag_id            = res_tag_id;
  assign tag.received_checksum = res_checksum;

endmodule

@@ src/rfid_afp_checker.sv @@
// ----------------------------------------------------------------------------
// RFID ASCII frame parser checker
// Port-level properties of the frame parser, bound to its top level.
// ----------------------------------------------------------------------------
`include "rfid_ascii_frame_parser_defines.svh"

module rfid_afp_checker
  import rfid_afp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                rx_valid,
  input logic                rx_ready,
  input logic                tag_valid,
  input logic                tag_ready,
  input logic [STATUS_W-1:0] tag_status,
  input logic [TAG_ID_W-1:0] tag_id,
  input logic [CHAR_W-1:0]   tag_checksum
);

  logic tag_stall;
  logic tag_error;

  assign tag_stall = tag_valid && !tag_ready;
  assign tag_error = (tag_status == ST_BAD_START) || (tag_status == ST_BAD_HEX) ||
                     (tag_status == ST_BAD_CR) || (tag_status == ST_BAD_LF) ||
                     (tag_status == ST_BAD_ETX);

  // A stalled verdict keeps its beat unchanged.
  `RAFP_ASSERT_NEXT(a_tag_hold, clk, rst, tag_stall, tag_valid && $stable(tag_status) && $stable(tag_id) && $stable(tag_checksum))

  // A new verdict only follows an accepted character.
  `RAFP_ASSERT_IMPLY(a_tag_cause, clk, rst, $rose(tag_valid), $past(rx_valid && rx_ready))

  // No character is taken while a verdict waits.
  `RAFP_ASSERT_IMPLY(a_rx_blocked, clk, rst, tag_stall, !rx_ready)

  // Framing errors carry cleared tag and checksum fields.
  `RAFP_ASSERT_IMPLY(a_error_fields, clk, rst, tag_valid && tag_error, tag_id == '0 && tag_checksum == '0)

endmodule

bind rfid_ascii_frame_parser rfid_afp_checker u_rfid_afp_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx.valid),
  .rx_ready     (rx.ready),
  .tag_valid    (tag.valid),
  .tag_ready    (tag.ready),
  .tag_status   (tag.status),
  .tag_id       (tag.tag_id),
  .tag_checksum (tag.received_checksum)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// RFID ASCII frame parser testbench
// Sends directed and random tag frames, some good, some with a wrong checksum,
// some broken at a random position, plus stray bytes. A local model of the
// parser predicts every verdict, and the testbench checks each verdict field
// by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import rfid_afp_pkg::*;

  localparam int unsigned TAG_BYTES  = 5;
  localparam int unsigned DATA_CHARS = 2 * TAG_BYTES;
  localparam int unsigned POS_CS_LO  = DATA_CHARS + 2;
  localparam int unsigned POS_CR     = DATA_CHARS + 3;
  localparam int unsigned POS_LF     = DATA_CHARS + 4;
  localparam int unsigned POS_ETX    = DATA_CHARS + 5;
  localparam int unsigned CHAR_COUNT = 1750;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_ID_W-1:0] tag_id;
    logic [CHAR_W-1:0]   checksum;
  } verdict_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    bit                drain;
  } pending_char_t;

  logic clk;
  logic rst;

  rfid_afp_byte_if   rx ();
  rfid_afp_result_if tag ();

  rfid_ascii_frame_parser #(
    .TAG_BYTES(TAG_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .tag(tag)
  );

  pending_char_t char_q[$];
  verdict_t      verdicts_due[$];
  int            owed_q;
  int            fail_count;
  int            chars_sent;
  int            status_seen[8];
  int            send_gap;
  int            stall_cnt;
  int            idle_cycles;
  bit            burst_in;
  bit            burst_out;

  logic [3:0]          frame_pos;
  logic [TAG_ID_W-1:0] id_acc;
  logic [CHAR_W-1:0]   cs_acc;
  logic [CHAR_W-1:0]   xor_acc;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int hex_nibble(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return int'(c - CH_ZERO);
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      return int'(c - CH_UC_A) + 10;
    end
    return -1;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + CHAR_W'(nib);
    end
    return CH_UC_A + CHAR_W'(nib - 4'd10);
  endfunction

  task automatic parse_char(input logic [CHAR_W-1:0] c, output bit got, output verdict_t v);
    int nib;
    got = 0;
    v   = '0;
    if (frame_pos == 0) begin
      if (c != CH_STX) begin
        got      = 1;
        v.status = ST_BAD_START;
      end else begin
        frame_pos = 4'd1;
      end
    end else if (frame_pos <= POS_CS_LO) begin
      nib = hex_nibble(c);
      if (nib < 0) begin
        got      = 1;
        v.status = ST_BAD_HEX;
      end else begin
        if (frame_pos <= DATA_CHARS) begin
          id_acc = {id_acc[TAG_ID_W-5:0], nib[3:0]};
          if (frame_pos[0] == 1'b0) begin
            xor_acc = xor_acc ^ id_acc[7:0];
          end
        end else begin
          cs_acc = {cs_acc[3:0], nib[3:0]};
        end
        frame_pos = frame_pos + 4'd1;
      end
    end else if (frame_pos == POS_CR) begin
      if (c != CH_CR) begin
        got      = 1;
        v.status = ST_BAD_CR;
      end else begin
        frame_pos = frame_pos + 4'd1;
      end
    end else if (frame_pos == POS_LF) begin
      if (c != CH_LF) begin
        got      = 1;
        v.status = ST_BAD_LF;
      end else begin
        frame_pos = frame_pos + 4'd1;
      end
    end else begin
      got = 1;
      if (c != CH_ETX) begin
        v.status = ST_BAD_ETX;
      end else begin
        v.status   = (cs_acc == xor_acc) ? ST_OK : ST_CS_MISMATCH;
        v.tag_id   = id_acc;
        v.checksum = cs_acc;
      end
    end
    if (got) begin
      frame_pos = '0;
      id_acc    = '0;
      cs_acc    = '0;
      xor_acc   = '0;
    end
  endtask

  function automatic logic [CHAR_W-1:0] corrupt_char(input int pos);
    if (pos == 0 || $urandom_range(0, 3) == 0) begin
      return CHAR_W'($urandom_range(0, 255));
    end
    if (pos <= POS_CS_LO) begin
      case ($urandom_range(0, 8))
        0: return "a";
        1: return "f";
        2: return "G";
        3: return "Z";
        4: return "/";
        5: return ":";
        6: return "@";
        7: return 8'hC1;
        default: return CH_CR;
      endcase
    end
    case ($urandom_range(0, 4))
      0: return CH_STX;
      1: return CH_ETX;
      2: return CH_LF;
      3: return CH_CR;
      default: return 8'h8D;
    endcase
  endfunction

  task automatic add_char(input logic [CHAR_W-1:0] c);
    char_q.push_back('{ch: c, drain: 1'b0});
  endtask

  task automatic add_frame(input logic [TAG_ID_W-1:0] id, input bit bad_cs, input int cut,
                           input bit drain);
    logic [CHAR_W-1:0] frame[16];
    logic [CHAR_W-1:0] cs;
    int                last;
    cs = '0;
    for (int i = 0; i < TAG_BYTES; i++) begin
      cs = cs ^ id[TAG_ID_W-1-8*i -: 8];
    end
    if (bad_cs) begin
      cs = cs ^ CHAR_W'($urandom_range(1, 255));
    end
    frame[0] = CH_STX;
    for (int k = 0; k < DATA_CHARS; k++) begin
      frame[1+k] = hex_char(id[TAG_ID_W-1-4*k -: 4]);
    end
    frame[DATA_CHARS+1] = hex_char(cs[7:4]);
    frame[POS_CS_LO]    = hex_char(cs[3:0]);
    frame[POS_CR]       = CH_CR;
    frame[POS_LF]       = CH_LF;
    frame[POS_ETX]      = CH_ETX;
    last = POS_ETX;
    if (cut >= 0) begin
      frame[cut] = corrupt_char(cut);
      last       = cut;
    end
    for (int i = 0; i <= last; i++) begin
      char_q.push_back('{ch: frame[i], drain: (i == 0) && drain});
    end
  endtask

  task automatic add_random_frames();
    int                  r;
    logic [TAG_ID_W-1:0] id;
    bit                  first;
    first = 1;
    while (char_q.size() < CHAR_COUNT) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: id = '0;
        1: id = '1;
        default: id = TAG_ID_W'({$urandom, $urandom});
      endcase
      if (r < 8) begin
        add_char(CHAR_W'($urandom_range(0, 255)));
      end else if (r < 55) begin
        add_frame(id, 1'b0, -1, first || $urandom_range(0, 29) == 0);
      end else if (r < 70) begin
        add_frame(id, 1'b1, -1, $urandom_range(0, 29) == 0);
      end else begin
        add_frame(id, 1'($urandom_range(0, 1)), $urandom_range(0, POS_ETX),
                  $urandom_range(0, 29) == 0);
      end
      first = 0;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    pending_char_t nxt;
    if (rst) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= '0;
      send_gap   <= 0;
    end else if (!rx.valid || rx.ready) begin
      if (send_gap != 0) begin
        rx.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (char_q.size() != 0 && char_q[0].drain && (rx.valid || owed_q != 0)) begin
        rx.valid <= 1'b0;
      end else if (char_q.size() != 0) begin
        nxt        = char_q.pop_front();
        rx.valid   <= 1'b1;
        rx.rx_byte <= nxt.ch;
        send_gap   <= pick_gap(burst_in);
        chars_sent++;
        if ($urandom_range(0, 79) == 0) begin
          burst_in = !burst_in;
        end
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    bit       got;
    verdict_t v;
    verdict_t want;
    if (rst) begin
      tag.ready <= 1'b0;
      stall_cnt <= 0;
      owed_q    <= 0;
    end else begin
      if (tag.valid && tag.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict status %0d", tag.status));
        end else begin
          want = verdicts_due.pop_front();
          status_seen[want.status]++;
          if (tag.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", tag.status, want.status));
          end
          if (tag.tag_id !== want.tag_id) begin
            report_mismatch($sformatf("tag_id %h, expected %h", tag.tag_id, want.tag_id));
          end
          if (tag.received_checksum !== want.checksum) begin
            report_mismatch($sformatf("received_checksum %h, expected %h",
                                      tag.received_checksum, want.checksum));
          end
        end
      end
      if (rx.valid && rx.ready) begin
        parse_char(rx.rx_byte, got, v);
        if (got) begin
          verdicts_due.push_back(v);
        end
      end
      owed_q <= verdicts_due.size();
      if (stall_cnt != 0) begin
        tag.ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        tag.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_cnt <= pick_gap(burst_out);
        end
      end
      if ($urandom_range(0, 199) == 0) begin
        burst_out = !burst_out;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((rx.valid && rx.ready) || (tag.valid && tag.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a beat", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    tag.ready  = 1'b0;
    frame_pos  = '0;
    id_acc     = '0;
    cs_acc     = '0;
    xor_acc    = '0;

    add_char(8'hFF);
    add_frame('1, 1'b0, -1, 1'b1);
    add_char(CH_STX);
    add_char("a");
    add_char(CH_STX);
    add_char(":");
    add_char(8'h00);
    add_random_frames();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (char_q.size() != 0 || rx.valid || owed_q != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    end
    $display("Sent %0d characters in good, mismatched, broken and stray-byte frames.",
             chars_sent);
    $display("Verdicts: ok %0d, bad start %0d, bad hex %0d, bad cr %0d, bad lf %0d, %s %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_BAD_START], status_seen[ST_BAD_HEX],
             status_seen[ST_BAD_CR], status_seen[ST_BAD_LF], "bad etx",
             status_seen[ST_BAD_ETX], "checksum mismatch", status_seen[ST_CS_MISMATCH]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
